>>> src/stis_pkg.sv
package stis_pkg;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DUMP   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Outcome of the shared signed comparator.
  typedef struct packed {
    logic lt;   // a < b
    logic eq;   // a == b
  } cmp_t;

endpackage

>>> src/stis_ram.sv
module stis_ram import stis_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CAPACITY,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic signed [DATA_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> src/stis_cmp.sv
module stis_cmp import stis_pkg::*; (
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output cmp_t                     res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

>>> src/sorted_table_insert_search_core.sv
// Channel   Direction  Signals                                      Beat taken when
// request   in         start, req_type, value                       start && !busy
// result    out        res_strobe, entry, found, full_res,          res_strobe (one cycle,
//                      empty_res, last                              no back-pressure)
//
// Steps: with n stored entries, an insert moves one entry up per step, from the top
// down to the slot p the value lands in; a search visits entries from slot 0 up (at
// most n); a dump streams out all n entries. Each step is one read of the
// table RAM plus one pass through the shared comparator. Full insert, empty
// search/dump and an unused code finish in the accept cycle.
// Reset: rst is synchronous, clears the sequencer and the entry count; the table
// itself is not cleared. The result side cannot stall; each result is shown once.
module sorted_table_insert_search_core import stis_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic signed [DATA_W-1:0] value,
  // result channel
  output logic                     res_strobe,
  output logic signed [DATA_W-1:0] entry,
  output logic                     found,
  output logic                     full_res,
  output logic                     empty_res,
  output logic                     last
);

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INS_CMP = 5'b00010,  // walk down from the top, moving entries up one slot
    S_INS_PUT = 5'b00100,  // all entries moved: value goes into slot 0
    S_SRC_CMP = 5'b01000,  // walk up from slot 0 until hit or passed
    S_DMP_OUT = 5'b10000   // stream entries out in order
  } state_t;

  state_t                   state, state_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic [AW-1:0]            idx, idx_next;
  logic signed [DATA_W-1:0] val, val_next;

  logic                     strobe_next, found_next, full_next, empty_next, last_next;
  logic signed [DATA_W-1:0] entry_next;

  // RAM and comparator hookup
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic signed [DATA_W-1:0] wdata, rdata;
  cmp_t                     cmp;

  logic                     accept;
  logic [AW-1:0]            last_idx;
  logic                     tbl_full;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign last_idx = AW'(cnt - CW'(1));
  assign tbl_full = (cnt == CW'(CAPACITY));

  stis_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // One compare per step: latched request value against the entry just read.
  stis_cmp u_cmp (
    .a   (val),
    .b   (rdata),
    .res (cmp)
  );

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    idx_next    = idx;
    val_next    = val;
    we          = 1'b0;
    waddr       = AW'(idx + AW'(1));
    wdata       = rdata;
    raddr       = idx;
    strobe_next = 1'b0;
    entry_next  = entry;
    found_next  = 1'b0;
    full_next   = 1'b0;
    empty_next  = 1'b0;
    last_next   = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          val_next = value;
          unique case (req_t'(req_type))
            REQ_INSERT: begin
              raddr = last_idx;
              if (tbl_full) begin
                strobe_next = 1'b1;
                entry_next  = value;
                full_next   = 1'b1;
              end else if (cnt == '0) begin
                state_next = S_INS_PUT;
              end else begin
                idx_next   = last_idx;
                state_next = S_INS_CMP;
              end
            end
            REQ_SEARCH: begin
              raddr    = '0;
              idx_next = '0;
              if (cnt == '0) begin
                strobe_next = 1'b1;
                entry_next  = value;
              end else begin
                state_next = S_SRC_CMP;
              end
            end
            REQ_DUMP: begin
              raddr    = '0;
              idx_next = '0;
              if (cnt == '0) begin
                strobe_next = 1'b1;
                entry_next  = '0;
                empty_next  = 1'b1;
              end else begin
                state_next = S_DMP_OUT;
              end
            end
            default: ;  // unused code: dropped, no result
          endcase
        end
      end

      S_INS_CMP: begin
        we = 1'b1;
        if (cmp.lt || cmp.eq) begin
          // entry >= value: move it up and keep walking down
          wdata = rdata;
          if (idx == '0) begin
            state_next = S_INS_PUT;
          end else begin
            idx_next = AW'(idx - AW'(1));
            raddr    = AW'(idx - AW'(1));
          end
        end else begin
          wdata       = val;
          cnt_next    = CW'(cnt + CW'(1));
          strobe_next = 1'b1;
          entry_next  = val;
          state_next  = S_IDLE;
        end
      end

      S_INS_PUT: begin
        we          = 1'b1;
        waddr       = '0;
        wdata       = val;
        cnt_next    = CW'(cnt + CW'(1));
        strobe_next = 1'b1;
        entry_next  = val;
        state_next  = S_IDLE;
      end

      S_SRC_CMP: begin
        if (cmp.eq || cmp.lt || (idx == last_idx)) begin
          strobe_next = 1'b1;
          entry_next  = val;
          found_next  = cmp.eq;
          state_next  = S_IDLE;
        end else begin
          idx_next = AW'(idx + AW'(1));
          raddr    = AW'(idx + AW'(1));
        end
      end

      S_DMP_OUT: begin
        strobe_next = 1'b1;
        entry_next  = rdata;
        last_next   = (idx == last_idx);
        if (idx == last_idx) begin
          state_next = S_IDLE;
        end else begin
          idx_next = AW'(idx + AW'(1));
          raddr    = AW'(idx + AW'(1));
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      res_strobe <= strobe_next;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    val       <= val_next;
    entry     <= entry_next;
    found     <= found_next;
    full_res  <= full_next;
    empty_res <= empty_next;
    last      <= last_next;
  end

endmodule
